### sv/binary_morph_erode_dilate_core_assert.svh
// Assertion macros for the binary morphology core and its checker.
// No dependencies; include with the bare file name.
`ifndef BINARY_MORPH_ERODE_DILATE_CORE_ASSERT_SVH
`define BINARY_MORPH_ERODE_DILATE_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define BMED_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define BMED_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/bmed_pkg.sv
// Shared constants for the binary morphology erode/dilate core.
// No dependencies.
package bmed_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int RADIUS_W   = 3;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int Y_W        = 13;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;
    localparam logic OP_PIXEL    = 1'b0;
    localparam logic OP_DRAIN    = 1'b1;

    localparam logic [PIX_W-1:0]    PIX_FULL   = 8'hFF;
    localparam logic [PIX_W-1:0]    PIX_ZERO   = 8'h00;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd1;
    localparam logic [FH_W-1:0]     HEIGHT_RST = 12'd480;
    localparam int                  WIDTH_RST  = 640;

endpackage

### sv/bmed_line_ram.sv
// Single-port-write, single-port-read line store with registered read data.
// No package dependencies.
module bmed_line_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 14
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/binary_morph_erode_dilate_core.sv
// Binary erode/dilate core over a raster-order 8-bit mask stream.
// Depends on bmed_pkg and bmed_line_ram.
//
// Send a frame of frame_width x frame_height pixels (tuser = 0), then radius
// rows of drain transactions (tuser = 1) that replicate the last row. Each
// result is 0 or 255; results lag the input by radius rows and radius
// columns, and tlast marks the last result of one input transaction, tuser
// marks the last result of the frame. The core takes one pixel per clock
// unless stalled; from row radius on, the transaction in the last column
// of a row emits radius+1 results, one per cycle from the window stage
// while m_tready is high, so the input pauses at each row end. The line
// store is one memory word per column holding one bit for each of the last
// 2*MAX_RADIUS rows; every column is read once per row and written back
// once per frame row, so a word is never read while its own write is still
// in flight. No clearing pass runs after reset. Write registers only while
// idle.
module binary_morph_erode_dilate_core #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel
    input  logic [0:0]                     s_tuser,   // [0] op (1 drain)
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] value
    output logic                           m_tlast,
    output logic [0:0]                     m_tuser,   // [0] end_of_frame
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmed_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS;
    localparam int WIN_LEN    = STORE_ROWS + 1;
    localparam int SW         = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int KW         = $clog2(WIN_LEN);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int CW         = $clog2(MAX_RADIUS + 2);
    localparam int MW         = SW + 2;
    localparam int WIDTH_INIT = (bmed_pkg::WIDTH_RST < MAX_WIDTH) ?
                                bmed_pkg::WIDTH_RST : MAX_WIDTH;

    // ---------------- configuration registers ----------------
    logic                            mode_reg, mode_next;
    logic [bmed_pkg::RADIUS_W-1:0]   radius_reg, radius_next;
    logic [bmed_pkg::FW_W-1:0]       width_reg, width_next;
    logic [bmed_pkg::FH_W-1:0]       height_reg, height_next;

    logic [bmed_pkg::FH_W-1:0]       min_dim;
    logic [bmed_pkg::FH_W-1:0]       rad_lim;
    logic [bmed_pkg::RADIUS_W-1:0]   rad_v;
    logic [bmed_pkg::FW_W-1:0]       wid_v;
    logic [bmed_pkg::FH_W-1:0]       hgt_v;
    logic [bmed_pkg::RADIUS_W:0]     side;

    assign cfg_ready = 1'b1;
    assign side      = {radius_reg, 1'b1};

    always_comb begin
        mode_next   = mode_reg;
        radius_next = radius_reg;
        width_next  = width_reg;
        height_next = height_reg;
        min_dim = ({1'b0, width_reg} < height_reg) ? {1'b0, width_reg} : height_reg;
        rad_lim = (min_dim - 12'd1) >> 1;
        rad_v   = cfg_data[bmed_pkg::RADIUS_W-1:0];
        if (rad_v == '0) begin
            rad_v = 3'd1;
        end
        if (int'(rad_v) > MAX_RADIUS) begin
            rad_v = bmed_pkg::RADIUS_W'(MAX_RADIUS);
        end
        if ({9'd0, rad_v} > rad_lim) begin
            rad_v = rad_lim[bmed_pkg::RADIUS_W-1:0];
        end
        wid_v = cfg_data[bmed_pkg::FW_W-1:0];
        if (wid_v < {7'd0, side}) begin
            wid_v = {7'd0, side};
        end
        if (int'(wid_v) > MAX_WIDTH) begin
            wid_v = bmed_pkg::FW_W'(MAX_WIDTH);
        end
        hgt_v = cfg_data;
        if (hgt_v < {8'd0, side}) begin
            hgt_v = {8'd0, side};
        end
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bmed_pkg::CFG_MODE:   mode_next   = cfg_data[0];
                bmed_pkg::CFG_RADIUS: radius_next = rad_v;
                bmed_pkg::CFG_WIDTH:  width_next  = wid_v;
                bmed_pkg::CFG_HEIGHT: height_next = hgt_v;
                default: ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    logic [XW-1:0]              col_reg, col_next;
    logic [bmed_pkg::Y_W-1:0]   row_reg, row_next;
    logic [SW-1:0]              slot_reg, slot_next;

    logic                       drain_phase;
    logic                       take;
    logic                       last_col;
    logic                       frame_end;
    logic [bmed_pkg::Y_W-1:0]   last_row;
    logic [bmed_pkg::Y_W-1:0]   rad_y;
    logic [CW-1:0]              emit_n;
    logic                       cur_bit;

    // ---------------- stage 0: line store read ----------------
    logic                       s0_valid_reg, s0_valid_next;
    logic [XW-1:0]              s0_x_reg;
    logic [bmed_pkg::Y_W-1:0]   s0_y_reg;
    logic [SW-1:0]              s0_slot_reg;
    logic [KW-1:0]              s0_d_reg;
    logic                       s0_bit_reg;
    logic                       s0_drain_reg;
    logic                       s0_xzero_reg;
    logic [CW-1:0]              s0_cnt_reg;
    logic                       s0_eof_reg;
    logic                       s0_adv;

    logic [STORE_ROWS-1:0]      rd_word;
    logic [STORE_ROWS-1:0]      wr_word;
    logic [WIN_LEN-1:0]         tap_bits;
    logic [WIN_LEN-1:0]         kmask;
    logic                       col_bit;

    // ---------------- stage 1: row window and burst ----------------
    logic [WIN_LEN-1:0]         win_reg, win_next;
    logic                       s1_col_reg, s1_col_next;
    logic [CW-1:0]              s1_left_reg, s1_left_next;
    logic                       s1_eof_reg, s1_eof_next;
    logic                       s1_free;
    logic                       win_hit;

    // ---------------- output register ----------------
    logic                       m_valid_reg, m_valid_next;
    logic                       m_value_reg, m_value_next;
    logic                       m_last_reg, m_last_next;
    logic                       m_eof_reg, m_eof_next;
    logic                       out_free;

    assign last_row    = {1'b0, height_reg} - 13'd1;
    assign rad_y       = {10'd0, radius_reg};
    assign drain_phase = row_reg >= {1'b0, height_reg};
    assign last_col    = ({1'b0, 11'(col_reg)} + 12'd1) >= {1'b0, width_reg};
    assign frame_end   = last_col && (row_reg >= last_row + rad_y);
    assign s_tready    = !s0_valid_reg || s0_adv;
    // drop transactions of the wrong kind: they change nothing
    assign take        = s_tvalid && s_tready && (s_tuser[0] == drain_phase);
    assign cur_bit     = (mode_reg == bmed_pkg::MODE_DILATE) ?
                         (s_tdata != bmed_pkg::PIX_ZERO) : (s_tdata == bmed_pkg::PIX_FULL);

    always_comb begin
        emit_n = '0;
        if (row_reg >= rad_y) begin
            if (last_col) begin
                emit_n = CW'(radius_reg) + CW'(1);
            end else if (12'(radius_reg) <= 12'(col_reg)) begin
                emit_n = CW'(1);
            end
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (take) begin
            if (frame_end) begin
                col_next  = '0;
                row_next  = '0;
                slot_next = '0;
            end else if (last_col) begin
                col_next  = '0;
                row_next  = row_reg + 13'd1;
                slot_next = (int'(slot_reg) == STORE_ROWS - 1) ? '0 : slot_reg + SW'(1);
            end else begin
                col_next  = col_reg + XW'(1);
            end
        end
    end

    assign s0_valid_next = take ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_reg);

    always_ff @(posedge aclk) begin
        if (take) begin
            s0_x_reg     <= col_reg;
            s0_y_reg     <= row_reg;
            s0_slot_reg  <= slot_reg;
            s0_d_reg     <= drain_phase ? KW'(row_reg - last_row) : '0;
            s0_bit_reg   <= cur_bit;
            s0_drain_reg <= drain_phase;
            s0_xzero_reg <= (col_reg == '0);
            s0_cnt_reg   <= emit_n;
            s0_eof_reg   <= frame_end;
        end
    end

    bmed_line_ram #(
        .DEPTH (MAX_WIDTH),
        .DW    (STORE_ROWS)
    ) u_line_ram (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (rd_word),
        .wr_en   (s0_adv && !s0_drain_reg),
        .wr_addr (s0_x_reg),
        .wr_data (wr_word)
    );

    // Gather the column: tap k looks k rows up, clamped to row 0 at the
    // top and to the last frame row while draining.
    always_comb begin
        logic [KW-1:0] off;
        logic [MW-1:0] sl;
        tap_bits = '0;
        kmask    = '0;
        for (int k = 0; k < WIN_LEN; k++) begin
            off = (KW'(k) < s0_d_reg) ? s0_d_reg : KW'(k);
            sl  = MW'(s0_slot_reg) + MW'(STORE_ROWS) - MW'(off);
            if (sl >= MW'(STORE_ROWS)) begin
                sl = sl - MW'(STORE_ROWS);
            end
            if (off == '0) begin
                tap_bits[k] = s0_bit_reg;
            end else if (s0_y_reg < bmed_pkg::Y_W'(off)) begin
                tap_bits[k] = (s0_y_reg == '0) ? s0_bit_reg : rd_word[0];
            end else begin
                tap_bits[k] = rd_word[sl[SW-1:0]];
            end
            kmask[k] = (k <= 2 * int'(radius_reg));
        end
    end

    assign col_bit = (mode_reg == bmed_pkg::MODE_DILATE) ? |(tap_bits & kmask) :
                                                           &(tap_bits | ~kmask);

    always_comb begin
        wr_word = rd_word;
        wr_word[s0_slot_reg] = s0_bit_reg;
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s1_free  = (s1_left_reg == '0) || ((s1_left_reg == CW'(1)) && out_free);
    assign s0_adv   = s0_valid_reg && s1_free;
    assign win_hit  = (mode_reg == bmed_pkg::MODE_DILATE) ? |(win_reg & kmask) :
                                                            &(win_reg | ~kmask);

    always_comb begin
        win_next     = win_reg;
        s1_col_next  = s1_col_reg;
        s1_left_next = s1_left_reg;
        s1_eof_next  = s1_eof_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_eof_next   = m_eof_reg;
        if (out_free) begin
            m_valid_next = 1'b0;
        end
        // emit one result; shift the column in again for the next one
        if ((s1_left_reg != '0) && out_free) begin
            m_valid_next = 1'b1;
            m_value_next = win_hit;
            m_last_next  = (s1_left_reg == CW'(1));
            m_eof_next   = (s1_left_reg == CW'(1)) && s1_eof_reg;
            s1_left_next = s1_left_reg - CW'(1);
            if (s1_left_reg != CW'(1)) begin
                win_next = {win_reg[WIN_LEN-2:0], s1_col_reg};
            end
        end
        // load a new column; a row start fills the whole window
        if (s0_adv) begin
            win_next     = s0_xzero_reg ? {WIN_LEN{col_bit}} :
                                          {win_reg[WIN_LEN-2:0], col_bit};
            s1_col_next  = col_bit;
            s1_left_next = s0_cnt_reg;
            s1_eof_next  = s0_eof_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bmed_pkg::MODE_ERODE;
            radius_reg   <= bmed_pkg::RADIUS_RST;
            width_reg    <= bmed_pkg::FW_W'(WIDTH_INIT);
            height_reg   <= bmed_pkg::HEIGHT_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            s0_valid_reg <= 1'b0;
            win_reg      <= '0;
            s1_left_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            radius_reg   <= radius_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            slot_reg     <= slot_next;
            s0_valid_reg <= s0_valid_next;
            win_reg      <= win_next;
            s1_left_reg  <= s1_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_col_reg  <= s1_col_next;
        s1_eof_reg  <= s1_eof_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        m_eof_reg   <= m_eof_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg ? bmed_pkg::PIX_FULL : bmed_pkg::PIX_ZERO;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eof_reg;

endmodule

### sv/bmed_checker.sv
// Port-level checks for the binary morphology core, bound to its top level.
// Depends on binary_morph_erode_dilate_core_assert.svh.
`include "binary_morph_erode_dilate_core_assert.svh"

module bmed_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    `BMED_ASSERT_IMP(a_value_binary, aclk, aresetn, m_tvalid, (m_tdata == 8'h00) || (m_tdata == 8'hFF), "result not 0 or 255")
    `BMED_ASSERT_IMP(a_eof_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast, "frame end without tlast")
    `BMED_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `BMED_ASSERT_NXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")

endmodule

bind binary_morph_erode_dilate_core bmed_checker u_bmed_checker (.*);
